// ===== sv/mgttc_pkg.sv =====
package mgttc_pkg;

  // Build-time defaults for the top-level parameters
  localparam int unsigned GearMaxDef    = 50;
  localparam int unsigned DutyMaxDef    = 380;
  localparam int unsigned TickStepMsDef = 10;
  localparam int unsigned RunMinMsDef   = 100;
  localparam int unsigned RunMaxMsDef   = 600000;

  // Register reset values
  localparam logic [9:0] TuneStartRst  = 10'd650;
  localparam logic [9:0] TuneStopRst   = 10'd130;
  localparam logic [9:0] CoarseThrRst  = 10'd450;
  localparam logic [7:0] CoarseStepRst = 8'd50;
  localparam logic [7:0] FineStepRst   = 8'd10;
  localparam logic [9:0] CoarseHoldRst = 10'd800;
  localparam logic [9:0] FineHoldRst   = 10'd900;
  localparam logic [7:0] MarginRst     = 8'd30;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic [2:0] {
    FN_TICK     = 3'd0,
    FN_KEY_UP   = 3'd1,
    FN_KEY_DOWN = 3'd2,
    FN_RUN      = 3'd3,
    FN_SPEED    = 3'd4,
    FN_STOP     = 3'd5,
    FN_TUNE     = 3'd6,
    FN_STATUS   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    REG_TUNE_START  = 3'd0,
    REG_TUNE_STOP   = 3'd1,
    REG_COARSE_THR  = 3'd2,
    REG_COARSE_STEP = 3'd3,
    REG_FINE_STEP   = 3'd4,
    REG_COARSE_HOLD = 3'd5,
    REG_FINE_HOLD   = 3'd6,
    REG_MARGIN      = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    MSG_NONE       = 4'd0,
    MSG_OK_RUN     = 4'd1,
    MSG_OK_SPEED   = 4'd2,
    MSG_OK_STOP    = 4'd3,
    MSG_TUNE_START = 4'd4,
    MSG_GEAR_ERR   = 4'd5,
    MSG_TIME_ERR   = 4'd6,
    MSG_TUNE_ABORT = 4'd7,
    MSG_TUNE_STEP  = 4'd8,
    MSG_TUNE_MARK  = 4'd9,
    MSG_TUNE_NOMRK = 4'd10,
    MSG_TUNE_DONE  = 4'd11,
    MSG_SPAN_WARN  = 4'd12,
    MSG_RUN_DONE   = 4'd13,
    MSG_STATUS     = 4'd14
  } msg_kind_t;

  typedef struct packed {
    msg_kind_t   msg_kind;
    logic [5:0]  gear_now;
    logic        tune_on;
    logic [9:0]  tune_duty_now;
    logic        run_on;
    logic [19:0] remain_ms;
    logic [9:0]  value_a;
    logic [19:0] value_b;
    logic [9:0]  span;
    logic        last;
  } rec_t;

  function automatic rec_t mk_rec(input msg_kind_t kind, input logic [9:0] a,
                                  input logic [19:0] b, input logic [9:0] sp,
                                  input logic [5:0] g, input logic ton,
                                  input logic [9:0] duty, input logic ron,
                                  input logic [19:0] rem);
    rec_t r;
    r.msg_kind      = kind;
    r.gear_now      = g;
    r.tune_on       = ton;
    r.tune_duty_now = duty;
    r.run_on        = ron;
    r.remain_ms     = ron ? rem : 20'd0;
    r.value_a       = a;
    r.value_b       = b;
    r.span          = sp;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/mgttc_in_if.sv =====
interface mgttc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  gear_arg;
  logic [19:0] ms_arg;

  modport source (output valid, output func, output gear_arg, output ms_arg, input ready);
  modport sink   (input valid, input func, input gear_arg, input ms_arg, output ready);
endinterface

// ===== sv/mgttc_out_if.sv =====
interface mgttc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  msg_kind;
  logic [5:0]  gear_now;
  logic        tune_on;
  logic [9:0]  tune_duty_now;
  logic        run_on;
  logic [19:0] remain_ms;
  logic [9:0]  value_a;
  logic [19:0] value_b;
  logic [9:0]  span;
  logic        last;

  modport source (output valid, output msg_kind, output gear_now, output tune_on,
                  output tune_duty_now, output run_on, output remain_ms, output value_a,
                  output value_b, output span, output last, input ready);
  modport sink   (input valid, input msg_kind, input gear_now, input tune_on,
                  input tune_duty_now, input run_on, input remain_ms, input value_a,
                  input value_b, input span, input last, output ready);
endinterface

// ===== sv/motor_gear_timer_tune_controller.sv =====
// Motor gear / timed run / stall calibration controller. Each input item is one
// decoded event (tick, key up, key down, run, speed, stop, tune, status) and
// yields zero to three message items on the output channel, the final one
// flagged by last. An accepted item is held in an input register, is
// evaluated in a single pass against the controller state, and its messages
// land together in a 4-entry result queue that drains one item per cycle
// while the sink keeps ready high. Sustained rate is one input item per cycle
// while each produces at most one message and the sink keeps ready high;
// items that produce two or three messages (tune end, aborted commands) hold
// the input until the queue has room, since an item is only evaluated when
// three queue slots are free. Calibration settings sit in eight APB registers
// at byte address 4*index; the user must write them only while the block is
// idle, as the block does not enforce this. pready is tied high.
module motor_gear_timer_tune_controller #(
  parameter int unsigned GEAR_MAX     = mgttc_pkg::GearMaxDef,
  parameter int unsigned DUTY_MAX     = mgttc_pkg::DutyMaxDef,
  parameter int unsigned TICK_STEP_MS = mgttc_pkg::TickStepMsDef,
  parameter int unsigned RUN_MIN_MS   = mgttc_pkg::RunMinMsDef,
  parameter int unsigned RUN_MAX_MS   = mgttc_pkg::RunMaxMsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mgttc_in_if.sink                        in_ch,
  mgttc_out_if.source                     out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mgttc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mgttc_pkg::ApbDataW-1:0]  pwdata,
  output logic [mgttc_pkg::ApbDataW-1:0]  prdata,
  output logic                            pready
);

  localparam logic [5:0]  GearMax6  = 6'(GEAR_MAX);
  localparam logic [7:0]  GearMax8  = 8'(GEAR_MAX);
  localparam logic [9:0]  GearMax10 = 10'(GEAR_MAX);
  localparam logic [9:0]  DutyMax10 = 10'(DUTY_MAX);
  localparam logic [10:0] DutyMax11 = 11'(DUTY_MAX);
  localparam logic [9:0]  Tick10    = 10'(TICK_STEP_MS);
  localparam logic [19:0] Tick20    = 20'(TICK_STEP_MS);
  localparam logic [19:0] RunMin20  = 20'(RUN_MIN_MS);
  localparam logic [19:0] RunMax20  = 20'(RUN_MAX_MS);

  // ---------------- configuration registers ----------------
  logic [9:0] tune_start_r, tune_stop_r, coarse_thr_r, coarse_hold_r, fine_hold_r;
  logic [7:0] coarse_step_r, fine_step_r, margin_r;
  logic       cfg_wr;
  mgttc_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = mgttc_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tune_start_r  <= mgttc_pkg::TuneStartRst;
      tune_stop_r   <= mgttc_pkg::TuneStopRst;
      coarse_thr_r  <= mgttc_pkg::CoarseThrRst;
      coarse_step_r <= mgttc_pkg::CoarseStepRst;
      fine_step_r   <= mgttc_pkg::FineStepRst;
      coarse_hold_r <= mgttc_pkg::CoarseHoldRst;
      fine_hold_r   <= mgttc_pkg::FineHoldRst;
      margin_r      <= mgttc_pkg::MarginRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mgttc_pkg::REG_TUNE_START:  tune_start_r  <= pwdata[9:0];
        mgttc_pkg::REG_TUNE_STOP:   tune_stop_r   <= pwdata[9:0];
        mgttc_pkg::REG_COARSE_THR:  coarse_thr_r  <= pwdata[9:0];
        mgttc_pkg::REG_COARSE_STEP: coarse_step_r <= pwdata[7:0];
        mgttc_pkg::REG_FINE_STEP:   fine_step_r   <= pwdata[7:0];
        mgttc_pkg::REG_COARSE_HOLD: coarse_hold_r <= pwdata[9:0];
        mgttc_pkg::REG_FINE_HOLD:   fine_hold_r   <= pwdata[9:0];
        default:                    margin_r      <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mgttc_pkg::REG_TUNE_START:  prdata = {22'd0, tune_start_r};
      mgttc_pkg::REG_TUNE_STOP:   prdata = {22'd0, tune_stop_r};
      mgttc_pkg::REG_COARSE_THR:  prdata = {22'd0, coarse_thr_r};
      mgttc_pkg::REG_COARSE_STEP: prdata = {24'd0, coarse_step_r};
      mgttc_pkg::REG_FINE_STEP:   prdata = {24'd0, fine_step_r};
      mgttc_pkg::REG_COARSE_HOLD: prdata = {22'd0, coarse_hold_r};
      mgttc_pkg::REG_FINE_HOLD:   prdata = {22'd0, fine_hold_r};
      default:                    prdata = {24'd0, margin_r};
    endcase
  end

  // ---------------- input register ----------------
  logic        s1_vld_r;
  logic [2:0]  s1_func_r;
  logic [7:0]  s1_garg_r;
  logic [19:0] s1_marg_r;
  logic        s1_go;

  // ---------------- result queue ----------------
  mgttc_pkg::rec_t q_mem [4];
  logic [1:0] q_head_r, q_tail_r;
  logic [2:0] q_cnt_r, q_cnt_pop, q_cnt_nxt;
  logic       q_pop;

  assign out_ch.valid = (q_cnt_r != 3'd0);
  assign q_pop        = out_ch.valid && out_ch.ready;
  assign q_cnt_pop    = q_cnt_r - {2'd0, q_pop};
  // evaluate only when a worst-case burst of three messages fits
  assign s1_go        = s1_vld_r && (q_cnt_pop <= 3'd1);
  assign in_ch.ready  = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_func_r <= in_ch.func;
      s1_garg_r <= in_ch.gear_arg;
      s1_marg_r <= in_ch.ms_arg;
    end
  end

  // ---------------- controller state ----------------
  logic [5:0]  gear_r, gear_nxt;
  logic        run_act_r, run_act_nxt;
  logic [19:0] run_rem_r, run_rem_nxt;
  logic [5:0]  run_cg_r, run_cg_nxt;
  logic [19:0] run_cms_r, run_cms_nxt;
  logic        tune_act_r, tune_act_nxt;
  logic [9:0]  tune_duty_r, tune_duty_nxt;
  logic [9:0]  tune_wait_r, tune_wait_nxt;

  // sweep step: coarse above the threshold, fine at or below
  logic        coarse_c;
  logic [7:0]  step_c;
  logic [9:0]  hold_c;
  logic        step_ok_c;
  logic [9:0]  step_duty_c;
  assign coarse_c    = tune_duty_r > coarse_thr_r;
  assign step_c      = coarse_c ? coarse_step_r : fine_step_r;
  assign hold_c      = coarse_c ? coarse_hold_r : fine_hold_r;
  assign step_ok_c   = {1'b0, tune_duty_r} >= ({1'b0, tune_stop_r} + {3'd0, step_c});
  assign step_duty_c = tune_duty_r - {2'd0, step_c};

  // end of sweep: floor = mark + margin clamped to DUTY_MAX
  logic [10:0] flo_sum_c;
  logic [9:0]  flo_c, span_c;
  logic        warn_c;
  assign flo_sum_c = {1'b0, tune_duty_r} + {3'd0, margin_r};
  assign flo_c     = (flo_sum_c > DutyMax11) ? DutyMax10 : flo_sum_c[9:0];
  assign span_c    = DutyMax10 - flo_c;
  assign warn_c    = span_c < GearMax10;

  logic [19:0] rem_vis_c;
  assign rem_vis_c = run_act_r ? run_rem_r : 20'd0;

  mgttc_pkg::rec_t rec0_c, rec1_c, rec2_c, cmd_rec_c, abort_rec_c;
  logic [1:0] n_c;
  logic       end_c, marked_c, abort_c, is_cmd_c;
  logic [5:0] g_ab_c;

  always_comb begin
    gear_nxt      = gear_r;
    run_act_nxt   = run_act_r;
    run_rem_nxt   = run_rem_r;
    run_cg_nxt    = run_cg_r;
    run_cms_nxt   = run_cms_r;
    tune_act_nxt  = tune_act_r;
    tune_duty_nxt = tune_duty_r;
    tune_wait_nxt = tune_wait_r;
    end_c         = 1'b0;
    marked_c      = 1'b0;
    is_cmd_c      = 1'b0;
    abort_c       = tune_act_r;
    g_ab_c        = tune_act_r ? 6'd0 : gear_r;
    n_c           = 2'd0;
    rec0_c        = mgttc_pkg::mk_rec(mgttc_pkg::MSG_NONE, 10'd0, 20'd0, 10'd0,
                                      gear_r, tune_act_r, tune_duty_r, run_act_r, rem_vis_c);
    rec1_c        = rec0_c;
    rec2_c        = rec0_c;
    // abort leaves gear 0 and the sweep off; duty and run state stay
    abort_rec_c   = mgttc_pkg::mk_rec(mgttc_pkg::MSG_TUNE_ABORT, 10'd0, 20'd0, 10'd0,
                                      6'd0, 1'b0, tune_duty_r, run_act_r, rem_vis_c);
    cmd_rec_c     = mgttc_pkg::mk_rec(mgttc_pkg::MSG_GEAR_ERR, 10'd0, 20'd0, 10'd0,
                                      g_ab_c, 1'b0, tune_duty_r, run_act_r, rem_vis_c);

    unique case (mgttc_pkg::func_t'(s1_func_r))
      mgttc_pkg::FN_TICK: begin
        // sweep and timed run never run together
        if (tune_act_r) begin
          if (tune_wait_r > Tick10) begin
            tune_wait_nxt = tune_wait_r - Tick10;
          end else if (step_ok_c) begin
            tune_duty_nxt = step_duty_c;
            tune_wait_nxt = hold_c;
            rec0_c = mgttc_pkg::mk_rec(mgttc_pkg::MSG_TUNE_STEP, step_duty_c, 20'd0, 10'd0,
                                       gear_r, 1'b1, step_duty_c, run_act_r, rem_vis_c);
            n_c = 2'd1;
          end else begin
            end_c = 1'b1;
          end
        end else if (run_act_r) begin
          if (run_rem_r > Tick20) begin
            run_rem_nxt = run_rem_r - Tick20;
          end else begin
            run_rem_nxt = 20'd0;
            run_act_nxt = 1'b0;
            gear_nxt    = 6'd0;
            rec0_c = mgttc_pkg::mk_rec(mgttc_pkg::MSG_RUN_DONE, {4'd0, run_cg_r}, run_cms_r,
                                       10'd0, 6'd0, tune_act_r, tune_duty_r, 1'b0, 20'd0);
            n_c = 2'd1;
          end
        end
      end
      mgttc_pkg::FN_KEY_UP: begin
        if (tune_act_r) begin
          end_c    = 1'b1;
          marked_c = 1'b1;
        end else if (gear_r < GearMax6) begin
          gear_nxt = gear_r + 6'd1;
        end
      end
      mgttc_pkg::FN_KEY_DOWN: begin
        if (tune_act_r) begin
          end_c    = 1'b1;
          marked_c = 1'b1;
        end else if (gear_r != 6'd0) begin
          gear_nxt = gear_r - 6'd1;
        end
      end
      mgttc_pkg::FN_RUN: begin
        is_cmd_c = 1'b1;
        gear_nxt = g_ab_c;
        if (s1_garg_r > GearMax8) begin
          cmd_rec_c.msg_kind = mgttc_pkg::MSG_GEAR_ERR;
        end else if (s1_marg_r < RunMin20 || s1_marg_r > RunMax20) begin
          cmd_rec_c.msg_kind = mgttc_pkg::MSG_TIME_ERR;
        end else begin
          gear_nxt    = s1_garg_r[5:0];
          run_cg_nxt  = s1_garg_r[5:0];
          run_cms_nxt = s1_marg_r;
          run_act_nxt = 1'b1;
          run_rem_nxt = s1_marg_r;
          cmd_rec_c = mgttc_pkg::mk_rec(mgttc_pkg::MSG_OK_RUN, {2'd0, s1_garg_r}, s1_marg_r,
                                        10'd0, s1_garg_r[5:0], 1'b0, tune_duty_r, 1'b1,
                                        s1_marg_r);
        end
      end
      mgttc_pkg::FN_SPEED: begin
        is_cmd_c = 1'b1;
        gear_nxt = g_ab_c;
        if (s1_garg_r > GearMax8) begin
          cmd_rec_c.msg_kind = mgttc_pkg::MSG_GEAR_ERR;
        end else begin
          gear_nxt  = s1_garg_r[5:0];
          cmd_rec_c = mgttc_pkg::mk_rec(mgttc_pkg::MSG_OK_SPEED, {2'd0, s1_garg_r}, 20'd0,
                                        10'd0, s1_garg_r[5:0], 1'b0, tune_duty_r, run_act_r,
                                        rem_vis_c);
        end
      end
      mgttc_pkg::FN_STOP: begin
        is_cmd_c    = 1'b1;
        gear_nxt    = 6'd0;
        run_act_nxt = 1'b0;
        run_rem_nxt = 20'd0;
        cmd_rec_c   = mgttc_pkg::mk_rec(mgttc_pkg::MSG_OK_STOP, 10'd0, 20'd0, 10'd0,
                                        6'd0, 1'b0, tune_duty_r, 1'b0, 20'd0);
      end
      mgttc_pkg::FN_TUNE: begin
        // restart without abort message if already sweeping
        gear_nxt      = 6'd0;
        run_act_nxt   = 1'b0;
        run_rem_nxt   = 20'd0;
        tune_act_nxt  = 1'b1;
        tune_duty_nxt = tune_start_r;
        tune_wait_nxt = coarse_hold_r;
        rec0_c = mgttc_pkg::mk_rec(mgttc_pkg::MSG_TUNE_START, tune_start_r, 20'd0, 10'd0,
                                   6'd0, 1'b1, tune_start_r, 1'b0, 20'd0);
        n_c = 2'd1;
      end
      default: begin
        rec0_c = mgttc_pkg::mk_rec(mgttc_pkg::MSG_STATUS, 10'd0, 20'd0, 10'd0,
                                   gear_r, tune_act_r, tune_duty_r, run_act_r, rem_vis_c);
        n_c = 2'd1;
      end
    endcase

    // run / speed / stop: optional abort message ahead of the command's own
    if (is_cmd_c) begin
      tune_act_nxt = 1'b0;
      if (abort_c) begin
        tune_wait_nxt = 10'd0;
        rec0_c = abort_rec_c;
        rec1_c = cmd_rec_c;
        n_c    = 2'd2;
      end else begin
        rec0_c = cmd_rec_c;
        n_c    = 2'd1;
      end
    end

    // sweep end: mark or no mark, done, then span warning if narrow
    if (end_c) begin
      tune_act_nxt  = 1'b0;
      tune_wait_nxt = 10'd0;
      gear_nxt      = 6'd1;
      rec0_c = mgttc_pkg::mk_rec(marked_c ? mgttc_pkg::MSG_TUNE_MARK : mgttc_pkg::MSG_TUNE_NOMRK,
                                 tune_duty_r, {10'd0, flo_c}, span_c, gear_r, 1'b0,
                                 tune_duty_r, run_act_r, rem_vis_c);
      rec1_c = mgttc_pkg::mk_rec(mgttc_pkg::MSG_TUNE_DONE, tune_duty_r, {10'd0, flo_c}, span_c,
                                 6'd1, 1'b0, tune_duty_r, run_act_r, rem_vis_c);
      rec2_c = rec1_c;
      rec2_c.msg_kind = mgttc_pkg::MSG_SPAN_WARN;
      n_c = warn_c ? 2'd3 : 2'd2;
    end

    rec0_c.last = (n_c == 2'd1);
    rec1_c.last = (n_c == 2'd2);
    rec2_c.last = (n_c == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r      <= 6'd0;
      run_act_r   <= 1'b0;
      run_rem_r   <= 20'd0;
      run_cg_r    <= 6'd0;
      run_cms_r   <= 20'd0;
      tune_act_r  <= 1'b0;
      tune_duty_r <= 10'd0;
      tune_wait_r <= 10'd0;
    end else if (s1_go) begin
      gear_r      <= gear_nxt;
      run_act_r   <= run_act_nxt;
      run_rem_r   <= run_rem_nxt;
      run_cg_r    <= run_cg_nxt;
      run_cms_r   <= run_cms_nxt;
      tune_act_r  <= tune_act_nxt;
      tune_duty_r <= tune_duty_nxt;
      tune_wait_r <= tune_wait_nxt;
    end
  end

  // ---------------- queue bookkeeping ----------------
  logic [2:0] push_n;
  assign push_n    = s1_go ? {1'b0, n_c} : 3'd0;
  assign q_cnt_nxt = q_cnt_pop + push_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r <= 2'd0;
      q_tail_r <= 2'd0;
      q_cnt_r  <= 3'd0;
    end else begin
      q_cnt_r  <= q_cnt_nxt;
      q_tail_r <= q_tail_r + push_n[1:0];
      if (q_pop) begin
        q_head_r <= q_head_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      if (n_c != 2'd0) q_mem[q_tail_r]        <= rec0_c;
      if (n_c >= 2'd2) q_mem[q_tail_r + 2'd1] <= rec1_c;
      if (n_c == 2'd3) q_mem[q_tail_r + 2'd2] <= rec2_c;
    end
  end

  mgttc_pkg::rec_t head_rec;
  assign head_rec             = q_mem[q_head_r];
  assign out_ch.msg_kind      = head_rec.msg_kind;
  assign out_ch.gear_now      = head_rec.gear_now;
  assign out_ch.tune_on       = head_rec.tune_on;
  assign out_ch.tune_duty_now = head_rec.tune_duty_now;
  assign out_ch.run_on        = head_rec.run_on;
  assign out_ch.remain_ms     = head_rec.remain_ms;
  assign out_ch.value_a       = head_rec.value_a;
  assign out_ch.value_b       = head_rec.value_b;
  assign out_ch.span          = head_rec.span;
  assign out_ch.last          = head_rec.last;

endmodule

// ===== tb/mgttc_tb_pkg.sv =====
`timescale 1ns / 100ps
package mgttc_tb_pkg;
  import mgttc_pkg::*;

  // Tracks the controller state and queues the message items each event should produce.
  class motor_msg_predictor;
    logic [9:0]  start_duty, stop_duty, coarse_thr, coarse_hold, fine_hold;
    logic [7:0]  coarse_dec, fine_dec, margin;

    logic [5:0]  gear;
    logic        run_active;
    logic [19:0] run_left;
    logic [5:0]  run_gear;
    logic [19:0] run_ms;
    logic        tune_active;
    logic [9:0]  tune_duty;
    logic [9:0]  tune_wait;

    rec_t        expected_msgs[$];
    int          mismatches;

    function new();
      start_duty  = TuneStartRst;
      stop_duty   = TuneStopRst;
      coarse_thr  = CoarseThrRst;
      coarse_dec  = CoarseStepRst;
      fine_dec    = FineStepRst;
      coarse_hold = CoarseHoldRst;
      fine_hold   = FineHoldRst;
      margin      = MarginRst;
      gear        = '0;
      run_active  = 1'b0;
      run_left    = '0;
      run_gear    = '0;
      run_ms      = '0;
      tune_active = 1'b0;
      tune_duty   = '0;
      tune_wait   = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_TUNE_START:  start_duty  = v[9:0];
        REG_TUNE_STOP:   stop_duty   = v[9:0];
        REG_COARSE_THR:  coarse_thr  = v[9:0];
        REG_COARSE_STEP: coarse_dec  = v[7:0];
        REG_FINE_STEP:   fine_dec    = v[7:0];
        REG_COARSE_HOLD: coarse_hold = v[9:0];
        REG_FINE_HOLD:   fine_hold   = v[9:0];
        default:         margin      = v[7:0];
      endcase
    endfunction

    function void push_msg(msg_kind_t k, int unsigned a, int unsigned b, int unsigned sp);
      rec_t r;
      r.msg_kind      = k;
      r.gear_now      = gear;
      r.tune_on       = tune_active;
      r.tune_duty_now = tune_duty;
      r.run_on        = run_active;
      r.remain_ms     = run_active ? run_left : 20'd0;
      r.value_a       = a[9:0];
      r.value_b       = b[19:0];
      r.span          = sp[9:0];
      r.last          = 1'b0;
      expected_msgs.push_back(r);
    endfunction

    function void clamp_gear(int unsigned g);
      gear = 6'((g > GearMaxDef) ? GearMaxDef : g);
    endfunction

    function void stop_motor();
      run_active = 1'b0;
      run_left   = '0;
      clamp_gear(0);
    endfunction

    function void abort_sweep();
      tune_active = 1'b0;
      tune_wait   = '0;
      gear        = '0;
      push_msg(MSG_TUNE_ABORT, 0, 0, 0);
    endfunction

    // floor = mark + margin clamped to the duty ceiling; warn on a narrow span
    function void finish_sweep(bit marked);
      int unsigned mark_duty, flo, sp;
      mark_duty = 32'(tune_duty);
      flo = mark_duty + 32'(margin);
      if (flo > DutyMaxDef)
        flo = DutyMaxDef;
      sp = (flo < DutyMaxDef) ? DutyMaxDef - flo : 32'd0;
      tune_active = 1'b0;
      tune_wait   = '0;
      push_msg(msg_kind_t'(marked ? MSG_TUNE_MARK : MSG_TUNE_NOMRK), mark_duty, flo, sp);
      gear = 6'd1;
      push_msg(MSG_TUNE_DONE, mark_duty, flo, sp);
      if (sp < GearMaxDef)
        push_msg(MSG_SPAN_WARN, mark_duty, flo, sp);
    endfunction

    function void sweep_tick();
      int unsigned dec, hold;
      if (32'(tune_wait) > TickStepMsDef) begin
        tune_wait = 10'(32'(tune_wait) - TickStepMsDef);
        return;
      end
      if (tune_duty > coarse_thr) begin
        dec  = 32'(coarse_dec);
        hold = 32'(coarse_hold);
      end else begin
        dec  = 32'(fine_dec);
        hold = 32'(fine_hold);
      end
      if (32'(tune_duty) >= 32'(stop_duty) + dec) begin
        tune_duty = 10'(32'(tune_duty) - dec);
        tune_wait = 10'(hold);
        push_msg(MSG_TUNE_STEP, 32'(tune_duty), 0, 0);
      end else begin
        finish_sweep(1'b0);
      end
    endfunction

    function void note_event(func_t f, logic [7:0] garg, logic [19:0] marg);
      int   n0;
      rec_t r;
      n0 = expected_msgs.size();
      case (f)
        FN_TICK: begin
          if (tune_active)
            sweep_tick();
          if (run_active) begin
            if (32'(run_left) > TickStepMsDef) begin
              run_left = 20'(32'(run_left) - TickStepMsDef);
            end else begin
              run_left   = '0;
              run_active = 1'b0;
              clamp_gear(0);
              push_msg(MSG_RUN_DONE, 32'(run_gear), 32'(run_ms), 0);
            end
          end
        end
        FN_KEY_UP, FN_KEY_DOWN: begin
          if (tune_active)
            finish_sweep(1'b1);
          else if (f == FN_KEY_UP && 32'(gear) < GearMaxDef)
            gear = gear + 6'd1;
          else if (f == FN_KEY_DOWN && gear != 6'd0)
            gear = gear - 6'd1;
        end
        FN_RUN: begin
          if (tune_active)
            abort_sweep();
          if (32'(garg) > GearMaxDef) begin
            push_msg(MSG_GEAR_ERR, 0, 0, 0);
          end else if (32'(marg) < RunMinMsDef || 32'(marg) > RunMaxMsDef) begin
            push_msg(MSG_TIME_ERR, 0, 0, 0);
          end else begin
            clamp_gear(32'(garg));
            run_gear   = garg[5:0];
            run_ms     = marg;
            run_active = 1'b1;
            run_left   = marg;
            push_msg(MSG_OK_RUN, 32'(garg), 32'(marg), 0);
          end
        end
        FN_SPEED: begin
          if (tune_active)
            abort_sweep();
          if (32'(garg) > GearMaxDef) begin
            push_msg(MSG_GEAR_ERR, 0, 0, 0);
          end else begin
            clamp_gear(32'(garg));
            push_msg(MSG_OK_SPEED, 32'(garg), 0, 0);
          end
        end
        FN_STOP: begin
          if (tune_active)
            abort_sweep();
          stop_motor();
          push_msg(MSG_OK_STOP, 0, 0, 0);
        end
        FN_TUNE: begin
          stop_motor();
          tune_active = 1'b1;
          tune_duty   = start_duty;
          tune_wait   = coarse_hold;
          push_msg(MSG_TUNE_START, 32'(tune_duty), 0, 0);
        end
        default: push_msg(MSG_STATUS, 0, 0, 0);
      endcase
      if (expected_msgs.size() > n0) begin
        r = expected_msgs.pop_back();
        r.last = 1'b1;
        expected_msgs.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [19:0] want, logic [19:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_msg(rec_t got);
      rec_t want;
      if (expected_msgs.size() == 0) begin
        $error("msg_kind: expected no item, got %0d", got.msg_kind);
        mismatches++;
        return;
      end
      want = expected_msgs.pop_front();
      compare_field("msg_kind", 20'(want.msg_kind), 20'(got.msg_kind));
      compare_field("gear_now", 20'(want.gear_now), 20'(got.gear_now));
      compare_field("tune_on", 20'(want.tune_on), 20'(got.tune_on));
      compare_field("tune_duty_now", 20'(want.tune_duty_now), 20'(got.tune_duty_now));
      compare_field("run_on", 20'(want.run_on), 20'(got.run_on));
      compare_field("remain_ms", want.remain_ms, got.remain_ms);
      compare_field("value_a", 20'(want.value_a), 20'(got.value_a));
      compare_field("value_b", want.value_b, got.value_b);
      compare_field("span", 20'(want.span), 20'(got.span));
      compare_field("last", 20'(want.last), 20'(got.last));
    endfunction
  endclass

endpackage

// ===== tb/tb_motor_gear_timer_tune_controller.sv =====
`timescale 1ns / 100ps
module tb_motor_gear_timer_tune_controller;
  import mgttc_pkg::*;
  import mgttc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  // APB side; pready is tied high in the block but still honored here
  logic                psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata, prdata;
  logic                pready;

  mgttc_in_if  in_ch();
  mgttc_out_if out_ch();

  motor_gear_timer_tune_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  motor_msg_predictor msg_pred = new();
  rec_t               seen_msg;

  // percent of cycles the event source / message sink hold off
  int tx_idle_pct;
  int rx_idle_pct;

  always #4 clk = ~clk;

  // Sink backpressure: ready changes on the falling edge only.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Both channels observed at the rising edge. An accepted event updates the
  // predicted state and queues its messages; an accepted message is checked
  // against the oldest one queued. Messages pass the input register and the
  // result queue after their event, so the event is always noted first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        msg_pred.note_event(func_t'(in_ch.func), in_ch.gear_arg, in_ch.ms_arg);
      if (out_ch.valid && out_ch.ready) begin
        seen_msg.msg_kind      = msg_kind_t'(out_ch.msg_kind);
        seen_msg.gear_now      = out_ch.gear_now;
        seen_msg.tune_on       = out_ch.tune_on;
        seen_msg.tune_duty_now = out_ch.tune_duty_now;
        seen_msg.run_on        = out_ch.run_on;
        seen_msg.remain_ms     = out_ch.remain_ms;
        seen_msg.value_a       = out_ch.value_a;
        seen_msg.value_b       = out_ch.value_b;
        seen_msg.span          = out_ch.span;
        seen_msg.last          = out_ch.last;
        msg_pred.check_msg(seen_msg);
      end
    end
  end

  // All driving tasks start and end just after a falling edge.
  task automatic write_cfg(input reg_idx_t idx, input int unsigned value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    msg_pred.set_reg(idx, value);
  endtask

  task automatic write_all_cfg(input int unsigned start, input int unsigned stop,
                               input int unsigned thr, input int unsigned cdec,
                               input int unsigned fdec, input int unsigned chold,
                               input int unsigned fhold, input int unsigned mrg);
    write_cfg(REG_TUNE_START, start);
    write_cfg(REG_TUNE_STOP, stop);
    write_cfg(REG_COARSE_THR, thr);
    write_cfg(REG_COARSE_STEP, cdec);
    write_cfg(REG_FINE_STEP, fdec);
    write_cfg(REG_COARSE_HOLD, chold);
    write_cfg(REG_FINE_HOLD, fhold);
    write_cfg(REG_MARGIN, mrg);
  endtask

  task automatic send_event(input func_t f, input logic [7:0] garg, input logic [19:0] marg);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.func     = f;
    in_ch.gear_arg = garg;
    in_ch.ms_arg   = marg;
    in_ch.valid    = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Waits until every expected message is in, then idles on, since an event
  // with no message may still be in the input register.
  task automatic settle();
    while (msg_pred.expected_msgs.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // mostly legal gears, now and then out of range
  function automatic logic [7:0] pick_gear();
    if ($urandom_range(9) < 8)
      return 8'($urandom_range(GearMaxDef));
    return 8'($urandom_range(255, GearMaxDef + 1));
  endfunction

  // mostly short legal runs, plus both out-of-range sides and full-width noise
  function automatic logic [19:0] pick_ms();
    case ($urandom_range(9))
      0:       return 20'($urandom_range(RunMinMsDef - 1));
      1:       return 20'($urandom_range(20'hFFFFF, RunMaxMsDef + 1));
      2:       return 20'($urandom);
      default: return 20'($urandom_range(300, RunMinMsDef));
    endcase
  endfunction

  function automatic func_t pick_key();
    return func_t'($urandom_range(1) ? FN_KEY_UP : FN_KEY_DOWN);
  endfunction

  // Random traffic built mostly from realistic sequences: sweeps with ticks and
  // usually an ending, timed runs ticked toward completion, key bursts; the rest
  // is unconstrained noise that exercises every argument bit.
  task automatic random_traffic(input int n_events);
    int sent;
    int kind;
    int k;
    sent = 0;
    while (sent < n_events) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        send_event(FN_TUNE, 8'($urandom), 20'($urandom));
        k = $urandom_range(16);
        repeat (k) send_event(FN_TICK, 8'($urandom), 20'($urandom));
        case ($urandom_range(4))
          0, 1: send_event(pick_key(), 8'($urandom), 20'($urandom));
          2:    send_event(func_t'($urandom_range(int'(FN_STOP), int'(FN_RUN))),
                           pick_gear(), pick_ms());
          3:    send_event(FN_TUNE, 8'($urandom), 20'($urandom));
          default: ;  // sweep left running into the next sequence
        endcase
        sent += k + 2;
      end else if (kind < 60) begin
        send_event(FN_RUN, pick_gear(), pick_ms());
        k = $urandom_range(28, 8);
        repeat (k) begin
          case ($urandom_range(7))
            0:       send_event(pick_key(), 8'($urandom), 20'($urandom));
            1:       send_event(FN_STATUS, 8'($urandom), 20'($urandom));
            default: send_event(FN_TICK, 8'($urandom), 20'($urandom));
          endcase
        end
        sent += k + 1;
      end else if (kind < 75) begin
        k = $urandom_range(4, 1);
        repeat (k) send_event(pick_key(), 8'($urandom), 20'($urandom));
        sent += k;
      end else begin
        send_event(func_t'($urandom_range(7)), 8'($urandom), 20'($urandom));
        sent += 1;
      end
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.func     = FN_TICK;
    in_ch.gear_arg = '0;
    in_ch.ms_arg   = '0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    tx_idle_pct    = 18;
    rx_idle_pct    = 67;
    rst_n          = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Short sweep for the directed part: 200 -> 160 -> 120 (coarse), 100 (fine),
    // then the floor check fails. Large margin makes the keyed mark warn.
    write_all_cfg(200, 100, 150, 40, 20, 10, 20, 200);

    send_event(FN_STATUS, 8'hFF, 20'hFFFFF);
    send_event(FN_TICK, 8'd0, 20'd0);          // idle tick, no message
    send_event(FN_KEY_DOWN, 8'd0, 20'd0);      // gear already at 0
    send_event(FN_SPEED, 8'(GearMaxDef), 20'd0);
    send_event(FN_KEY_UP, 8'd0, 20'd0);        // gear already at max
    send_event(FN_SPEED, 8'd255, 20'd0);       // gear error
    send_event(FN_RUN, 8'(GearMaxDef + 1), 20'hFFFFF);  // gear error wins over time
    send_event(FN_RUN, 8'd0, 20'd0);           // time too short
    send_event(FN_RUN, 8'd7, 20'(RunMaxMsDef + 1)); // time too long
    send_event(FN_RUN, 8'(GearMaxDef), 20'(RunMaxMsDef));
    send_event(FN_TUNE, 8'd0, 20'd0);          // also stops the run
    send_event(FN_TICK, 8'd0, 20'd0);          // first coarse step
    send_event(FN_KEY_UP, 8'd0, 20'd0);        // mark, done, span warning
    send_event(FN_TUNE, 8'd0, 20'd0);
    send_event(FN_SPEED, 8'(GearMaxDef + 1), 20'd0);    // abort, then gear error
    send_event(FN_TUNE, 8'd0, 20'd0);
    send_event(FN_TUNE, 8'd0, 20'd0);          // restart, no abort
    send_event(FN_RUN, 8'd3, 20'(RunMinMsDef));     // abort, then run starts
    send_event(FN_TUNE, 8'd0, 20'd0);
    send_event(FN_STOP, 8'd0, 20'd0);          // abort, then stop
    send_event(FN_TUNE, 8'd0, 20'd0);
    repeat (5) send_event(FN_TICK, 8'd0, 20'd0);  // sweep runs out, no mark
    settle();

    // random settings, kept to short sweeps
    write_all_cfg($urandom_range(500, 150), $urandom_range(150, 50),
                  $urandom_range(400, 100), $urandom_range(120, 20),
                  $urandom_range(40, 5), $urandom_range(40), $urandom_range(40),
                  $urandom_range(255));
    random_traffic(25);
    settle();

    // all registers at zero: zero decrement keeps the sweep on one duty
    tx_idle_pct = 67;
    rx_idle_pct = 18;
    write_all_cfg(0, 0, 0, 0, 0, 0, 0, 0);
    random_traffic(20);
    settle();

    // all registers at full width
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_all_cfg(1023, 1023, 1023, 255, 255, 1023, 1023, 255);
    random_traffic(20);
    settle();

    if (msg_pred.mismatches == 0 && msg_pred.expected_msgs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mgttc_pkg.sv
sv/mgttc_in_if.sv
sv/mgttc_out_if.sv
sv/motor_gear_timer_tune_controller.sv
tb/mgttc_tb_pkg.sv
tb/tb_motor_gear_timer_tune_controller.sv
